// ----- src/hkt_pkg.sv -----
// ----------------------------------------------------------------------------
// hkt_pkg: shared types and constants of the held key tracker
// Function and message codes, controller states, and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package hkt_pkg;

  // Default table depth and configuration reset values
  localparam int DEFAULT_TABLE_DEPTH = 32;
  localparam logic [15:0] SYNC_INTERVAL_RST = 16'd30;
  localparam logic [15:0] RECENT_WINDOW_RST = 16'd1000;
  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  // Stored key: make code, E0, E1, virtual key
  localparam int KEY_W = 34;
  localparam int CFG_ADDR_W = 3;

  // Input function codes
  localparam logic [1:0] FUNC_KEY   = 2'd0;
  localparam logic [1:0] FUNC_FOCUS = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // Result message kinds
  localparam logic [1:0] KIND_EVENT  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ENTRY  = 2'd2;

  // Register indexes (paddr bit 2)
  localparam logic REG_SYNC_INTERVAL = 1'b0;
  localparam logic REG_RECENT_WINDOW = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_EVENT,
    ST_TICK_CHK,
    ST_SYNC_HDR,
    ST_SYNC_WALK,
    ST_SYNC_END
  } state_t;

  typedef struct packed {
    logic load;        // latch the input item
    logic focus_set;   // apply a focus change
    logic tick;        // advance the idle counters
    logic scan_clr;    // restart the table walk
    logic issue;       // read the next table slot
    logic walk;        // sync mode: emit valid slots as entries
    logic evt_commit;  // emit the event and update the table
    logic hdr;         // emit the sync header
    logic sync_done;   // close out the sync
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       issue_end;  // every slot has been read
    logic       scan_done;  // every slot has been compared
    logic       evt_pass;   // key event passes the focus gate
    logic       sync_go;    // a sync is due on this tick
  } sts_t;

endpackage

// ----- src/hkt_ram.sv -----
// ----------------------------------------------------------------------------
// hkt_ram: generic single write port, single read port RAM
// Registered read data; contents are undefined until written.
// ----------------------------------------------------------------------------
module hkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/hkt_regs.sv -----
// ----------------------------------------------------------------------------
// hkt_regs: configuration register file on the APB-style port
// Holds the sync interval and the recent activity window.
// ----------------------------------------------------------------------------
module hkt_regs
  import hkt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [15:0]           sync_interval,
  output logic [15:0]           recent_window
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Register writes, decoded on the word address bit
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_interval <= SYNC_INTERVAL_RST;
      recent_window <= RECENT_WINDOW_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SYNC_INTERVAL: sync_interval <= pwdata[15:0];
        REG_RECENT_WINDOW: recent_window <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (paddr[2])
      REG_SYNC_INTERVAL: prdata = {16'd0, sync_interval};
      REG_RECENT_WINDOW: prdata = {16'd0, recent_window};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// ----- src/hkt_dp.sv -----
// ----------------------------------------------------------------------------
// hkt_dp: datapath of the held key tracker
// Key table (RAM plus valid bits), slot walker with compare stage, focus
// flag, sequence number, idle counters and the registered result outputs.
// ----------------------------------------------------------------------------
module hkt_dp
  import hkt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [15:0] sync_interval,
  input  logic [15:0] recent_window,
  input  logic [1:0]  func,
  input  logic [15:0] make_code,
  input  logic        key_up,
  input  logic        ext_e0,
  input  logic        ext_e1,
  input  logic [15:0] virtual_key,
  input  logic        focus_on,
  output logic        strobe,
  output logic [1:0]  msg_kind,
  output logic [31:0] sequence_res,
  output logic [15:0] out_make_code,
  output logic        out_key_up,
  output logic        out_e0,
  output logic        out_e1,
  output logic [15:0] out_virtual_key,
  output logic [5:0]  held_count,
  output logic        dropped,
  output logic        last
);

  // Latched input item
  logic [1:0]       func_r;
  logic [KEY_W-1:0] key_r;
  logic             up_r;
  logic             focus_on_r;

  // Tracker state
  logic                   focus;
  logic [31:0]            seq;
  logic [15:0]            tss;
  logic [15:0]            tsa;
  logic [TABLE_DEPTH-1:0] valid;
  logic [CW-1:0]          held_cnt;

  // Slot walker
  logic [CW-1:0]    rd_cnt;
  logic             cmp_vld;
  logic [AW-1:0]    cmp_idx;
  logic [KEY_W-1:0] rdata;
  logic             slot_valid;
  logic             found;
  logic [AW-1:0]    found_idx;
  logic             free_found;
  logic [AW-1:0]    free_idx;
  logic [CW-1:0]    emit_cnt;

  // Table update decisions
  logic ram_we;
  logic evt_drop;
  logic evt_remove;
  logic entry_emit;
  logic emit;

  // Result next values
  logic [1:0]       kind_next;
  logic [KEY_W-1:0] key_next;
  logic             up_next;
  logic [5:0]       cnt_next;
  logic             drop_next;
  logic             last_next;

  assign slot_valid = valid[cmp_idx];
  assign evt_remove = up_r & found;
  assign evt_drop   = ~up_r & ~found & ~free_found;
  assign ram_we     = cmd.evt_commit & ~up_r & ~found & free_found;
  assign entry_emit = cmd.walk & cmp_vld & slot_valid;
  assign emit       = cmd.evt_commit | cmd.hdr | entry_emit;

  // Status to the controller
  assign sts.func      = func_r;
  assign sts.issue_end = (rd_cnt == CW'(TABLE_DEPTH));
  assign sts.scan_done = sts.issue_end & ~cmp_vld;
  assign sts.evt_pass  = focus | (up_r & found);
  assign sts.sync_go   = (tss >= sync_interval) &&
                         ((held_cnt != '0) || (focus && (tsa < recent_window)));

  hkt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (key_r),
    .raddr (rd_cnt[AW-1:0]),
    .rdata (rdata)
  );

  // Latch the input item
  always_ff @(posedge clk) begin
    if (rst) begin
      func_r <= FUNC_KEY;
    end else if (cmd.load) begin
      func_r <= func;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r      <= {make_code, ext_e0, ext_e1, virtual_key};
      up_r       <= key_up;
      focus_on_r <= focus_on;
    end
  end

  // Focus flag, sequence number and idle counters
  always_ff @(posedge clk) begin
    if (rst) begin
      focus <= 1'b0;
      seq   <= '0;
      tss   <= '0;
      tsa   <= '0;
    end else begin
      if (cmd.focus_set) begin
        focus <= focus_on_r;
        tss   <= '0;
        tsa   <= '0;
      end
      if (cmd.tick) begin
        if (tss != TICK_MAX) tss <= tss + 16'd1;
        if (tsa != TICK_MAX) tsa <= tsa + 16'd1;
      end
      if (cmd.evt_commit) begin
        seq <= seq + 32'd1;
        tsa <= '0;
      end
      if (cmd.sync_done) begin
        seq <= seq + 32'd1;
        tss <= '0;
      end
    end
  end

  // Valid bits and held count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      held_cnt <= '0;
    end else if (cmd.evt_commit) begin
      if (evt_remove) begin
        valid[found_idx] <= 1'b0;
        held_cnt         <= held_cnt - CW'(1);
      end else if (ram_we) begin
        valid[free_idx] <= 1'b1;
        held_cnt        <= held_cnt + CW'(1);
      end
    end
  end

  // Slot walker: read issue, then compare stage in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt     <= '0;
      cmp_vld    <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      emit_cnt   <= '0;
    end else if (cmd.scan_clr) begin
      rd_cnt     <= '0;
      cmp_vld    <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
      emit_cnt   <= '0;
    end else begin
      cmp_vld <= cmd.issue;
      if (cmd.issue) rd_cnt <= rd_cnt + CW'(1);
      if (cmp_vld && slot_valid && (rdata == key_r) && !found) found <= 1'b1;
      if (cmp_vld && !slot_valid && !free_found) free_found <= 1'b1;
      if (entry_emit) emit_cnt <= emit_cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= rd_cnt[AW-1:0];
    if (cmp_vld && slot_valid && (rdata == key_r) && !found) found_idx <= cmp_idx;
    if (cmp_vld && !slot_valid && !free_found) free_idx <= cmp_idx;
  end

  // Result selection
  always_comb begin
    kind_next = KIND_EVENT;
    key_next  = key_r;
    up_next   = up_r;
    cnt_next  = '0;
    drop_next = evt_drop;
    last_next = 1'b1;
    if (cmd.hdr) begin
      kind_next = KIND_HEADER;
      key_next  = '0;
      up_next   = 1'b0;
      cnt_next  = 6'(held_cnt);
      drop_next = 1'b0;
      last_next = (held_cnt == '0);
    end else if (entry_emit) begin
      kind_next = KIND_ENTRY;
      key_next  = rdata;
      up_next   = 1'b0;
      drop_next = 1'b0;
      last_next = (CW'(emit_cnt + CW'(1)) == held_cnt);
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      msg_kind        <= kind_next;
      sequence_res    <= seq;
      out_make_code   <= key_next[33:18];
      out_e0          <= key_next[17];
      out_e1          <= key_next[16];
      out_virtual_key <= key_next[15:0];
      out_key_up      <= up_next;
      held_count      <= cnt_next;
      dropped         <= drop_next;
      last            <= last_next;
    end
  end

`ifndef ASSERT_OFF
  // Held count tracks the valid bits
  a_held_cnt: assert property (@(posedge clk) disable iff (rst)
    held_cnt == CW'($countones(valid)))
    else $error("held count out of step with valid bits");

  // Sync entries carry the sequence number of their header
  a_entry_seq: assert property (@(posedge clk) disable iff (rst)
    (strobe && (msg_kind == KIND_ENTRY)) |-> (sequence_res == seq))
    else $error("sync entry sequence number advanced early");

  // A dropped key-down only happens with a full table
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (strobe && dropped) |-> (held_cnt == CW'(TABLE_DEPTH)))
    else $error("key dropped while table has room");
`endif

endmodule

// ----- src/hkt_ctrl.sv -----
// ----------------------------------------------------------------------------
// hkt_ctrl: controller of the held key tracker
// Sequences one item at a time: dispatch, then a focus change, a table scan
// and event commit, or a tick, sync check, header and walk over the table.
// ----------------------------------------------------------------------------
module hkt_ctrl
  import hkt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.func)
          FUNC_KEY: begin
            cmd.scan_clr = 1'b1;
            state_next   = ST_SCAN;
          end
          FUNC_FOCUS: begin
            cmd.focus_set = 1'b1;
            state_next    = ST_IDLE;
          end
          FUNC_TICK: begin
            cmd.tick   = 1'b1;
            state_next = ST_TICK_CHK;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        cmd.issue = ~sts.issue_end;
        if (sts.scan_done) state_next = ST_EVENT;
      end
      ST_EVENT: begin
        cmd.evt_commit = sts.evt_pass;
        state_next     = ST_IDLE;
      end
      ST_TICK_CHK: begin
        state_next = sts.sync_go ? ST_SYNC_HDR : ST_IDLE;
      end
      ST_SYNC_HDR: begin
        cmd.hdr      = 1'b1;
        cmd.scan_clr = 1'b1;
        state_next   = ST_SYNC_WALK;
      end
      ST_SYNC_WALK: begin
        cmd.issue = ~sts.issue_end;
        cmd.walk  = 1'b1;
        if (sts.scan_done) state_next = ST_SYNC_END;
      end
      ST_SYNC_END: begin
        cmd.sync_done = 1'b1;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  // An accepted item always makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start processing");

  // A sync header is only sent after a tick was dispatched
  a_hdr_after_tick: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SYNC_HDR) |-> ($past(state) == ST_TICK_CHK))
    else $error("sync header outside tick handling");
`endif

endmodule

// ----- src/held_key_tracker_with_sync_unit.sv -----
// ----------------------------------------------------------------------------
// held_key_tracker_with_sync_unit: held key tracker with periodic state sync
// Usage:
//   Input items are offered on func and the key/focus fields with start; a
//   transaction is accepted at a clock edge with start high and busy low.
//   Results appear on the result ports for one cycle each, marked by strobe;
//   last marks the final result of an item. The receiver cannot stall.
//   Configuration registers (sync_interval at 0x0, recent_window at 0x4) are
//   written over the APB-style port; the user must write them only while the
//   block is idle, which the block does not enforce. pready is tied high.
// Sequencing:
//   A focus change is applied in the dispatch state. A tick without sync
//   ends after the sync check. A key event scans every slot, then commits;
//   an event that passes the focus gate is strobed in the cycle after busy
//   drops. Tick with sync: the header is strobed after the sync check, then
//   entries stream one per valid slot as the walk reads the key table RAM
//   one slot per cycle. One item is in flight at a time; the slot walk over
//   the table RAM sets the item time.
// Reset:
//   rst (synchronous) clears all held keys, focus, sequence number and both
//   idle counters, and restores the register defaults.
// ----------------------------------------------------------------------------
module held_key_tracker_with_sync_unit
  import hkt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            func,
  input  logic [15:0]           make_code,
  input  logic                  key_up,
  input  logic                  ext_e0,
  input  logic                  ext_e1,
  input  logic [15:0]           virtual_key,
  input  logic                  focus_on,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // result channel
  output logic                  strobe,
  output logic [1:0]            msg_kind,
  output logic [31:0]           sequence_res,
  output logic [15:0]           out_make_code,
  output logic                  out_key_up,
  output logic                  out_e0,
  output logic                  out_e1,
  output logic [15:0]           out_virtual_key,
  output logic [5:0]            held_count,
  output logic                  dropped,
  output logic                  last
);

  cmd_t        cmd;
  sts_t        sts;
  logic [15:0] sync_interval;
  logic [15:0] recent_window;

  hkt_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .sync_interval (sync_interval),
    .recent_window (recent_window)
  );

  hkt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  hkt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .sync_interval   (sync_interval),
    .recent_window   (recent_window),
    .func            (func),
    .make_code       (make_code),
    .key_up          (key_up),
    .ext_e0          (ext_e0),
    .ext_e1          (ext_e1),
    .virtual_key     (virtual_key),
    .focus_on        (focus_on),
    .strobe          (strobe),
    .msg_kind        (msg_kind),
    .sequence_res    (sequence_res),
    .out_make_code   (out_make_code),
    .out_key_up      (out_key_up),
    .out_e0          (out_e0),
    .out_e1          (out_e1),
    .out_virtual_key (out_virtual_key),
    .held_count      (held_count),
    .dropped         (dropped),
    .last            (last)
  );

endmodule
